[rtl/cba_pkg.sv]
// Shared definitions for the chunked bitmap slot allocator.
// Default sizes, port widths, action and status codes. No dependencies.
package cba_pkg;

  localparam int NUM_CHUNKS_DEF    = 16;
  localparam int MAX_SLOTS_DEF     = 64;
  localparam int CONTEXT_WIDTH_DEF = 64;

  localparam int CFG_W       = 7;
  localparam int CTX_PORT_W  = 64;
  localparam int CHUNK_IDX_W = 4;
  localparam int SLOT_IDX_W  = 6;
  localparam int STATUS_W    = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(64);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK            = 2'd0,
    STATUS_POOL_FULL     = 2'd1,
    STATUS_NOT_OPENED    = 2'd2,
    STATUS_NOT_ALLOCATED = 2'd3
  } status_t;

endpackage

[rtl/chunked_bitmap_slot_allocator.sv]
// Top level of the chunked bitmap slot allocator: chunk and context memories,
// free-list head, sequencer and output register. Depends on cba_pkg and
// cba_slot_search.
//
//   channel  | signals                                   | dir
//   ---------+-------------------------------------------+-----
//   in       | in_valid in_ready action context_in       | in
//            | chunk_index slot_index                    |
//   out      | out_valid out_ready status given_chunk    | out
//            | given_slot context_out                    |
//   cfg      | cfg_valid cfg_ready cfg_data              | in
//
// The accept cycle reads the chunk entry and the context word; the search and
// write-back cycle then searches the bitmap, writes the chunk memory and, on
// allocation the context memory, and waits while the output register is full.
// Reset clears control state only; a fill count of opened chunks stands in
// for clearing the chunk memory, so no clearing pass is needed.
// cfg_ready is always high.
module chunked_bitmap_slot_allocator import cba_pkg::*; #(
  parameter int NUM_CHUNKS    = NUM_CHUNKS_DEF,
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int CONTEXT_WIDTH = CONTEXT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [CTX_PORT_W-1:0]  context_in,
  input  logic [CHUNK_IDX_W-1:0] chunk_index,
  input  logic [SLOT_IDX_W-1:0]  slot_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [CHUNK_IDX_W-1:0] given_chunk,
  output logic [SLOT_IDX_W-1:0]  given_slot,
  output logic [CTX_PORT_W-1:0]  context_out
);

  localparam int CI_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int LINK_W    = $clog2(NUM_CHUNKS + 1);
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LF_W      = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W     = (LINK_W > CHUNK_IDX_W) ? LINK_W : CHUNK_IDX_W;
  localparam int CTX_AW    = CI_W + SLOT_W;
  localparam int CTX_DEPTH = NUM_CHUNKS << SLOT_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_CHUNKS);

  typedef struct packed {
    logic                 on_list;
    logic [LINK_W-1:0]    link;
    logic [LF_W-1:0]      lowest_free;
    logic [MAX_SLOTS-1:0] slot_map;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t                   state;
  logic [CFG_W-1:0]         slots_cfg;
  logic [LINK_W-1:0]        head;
  logic [LINK_W-1:0]        head_next;
  logic [LINK_W-1:0]        opened;
  logic [LINK_W-1:0]        opened_next;

  logic                     act_q;
  logic [CTX_PORT_W-1:0]    ctx_in_q;
  logic [CHUNK_IDX_W-1:0]   chunk_q;
  logic [SLOT_IDX_W-1:0]    slot_q;

  entry_t                   chunk_mem [NUM_CHUNKS];
  entry_t                   chunk_rd;
  logic [CONTEXT_WIDTH-1:0] ctx_mem [CTX_DEPTH];
  logic [CONTEXT_WIDTH-1:0] ctx_rd;

  logic                     accept;
  logic                     calc_go;
  logic [CI_W-1:0]          rd_addr;
  logic [LF_W-1:0]          s_eff;

  logic                     use_new;
  logic                     pool_empty;
  logic [CI_W-1:0]          alloc_c;
  entry_t                   cur;
  logic                     chunk_we;
  logic [CI_W-1:0]          chunk_wa;
  entry_t                   chunk_wd;
  logic                     ctx_we;
  logic [CTX_AW-1:0]        ctx_wa;
  logic                     not_opened;
  logic                     slot_hit;

  status_t                  res_status;
  logic [CHUNK_IDX_W-1:0]   res_chunk;
  logic [SLOT_IDX_W-1:0]    res_slot;
  logic [CTX_PORT_W-1:0]    res_ctx;

  logic                     srch_found;
  logic [SLOT_W-1:0]        srch_slot;
  logic [MAX_SLOTS-1:0]     srch_bit;
  logic [LF_W-1:0]          srch_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign calc_go   = (state == ST_CALC) && (!out_valid || out_ready);
  assign rd_addr   = (action == ACT_FREE) ? CI_W'(chunk_index) : CI_W'(head);

  assign s_eff = (slots_cfg == '0) ? LF_W'(1) :
                 (slots_cfg > CFG_W'(MAX_SLOTS)) ? LF_W'(MAX_SLOTS) : LF_W'(slots_cfg);

  cba_slot_search #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_search (
    .slot_map  (cur.slot_map),
    .start     (cur.lowest_free),
    .limit     (s_eff),
    .found     (srch_found),
    .slot      (srch_slot),
    .slot_bit  (srch_bit),
    .next_open (srch_next)
  );

  always_comb begin
    use_new    = (head == NULL_LINK);
    pool_empty = use_new && (opened == NULL_LINK);
    alloc_c    = use_new ? CI_W'(opened) : CI_W'(head);
    cur        = chunk_rd;
    if (act_q == ACT_ALLOC && use_new) begin
      cur = '{on_list: 1'b1, link: NULL_LINK, lowest_free: '0, slot_map: '0};
    end
    not_opened = CMP_W'(chunk_q) >= CMP_W'(opened);
    slot_hit   = (CFG_W'(slot_q) < CFG_W'(s_eff)) && chunk_rd.slot_map[SLOT_W'(slot_q)];

    head_next   = head;
    opened_next = opened;
    chunk_we    = 1'b0;
    chunk_wa    = alloc_c;
    chunk_wd    = cur;
    ctx_we      = 1'b0;
    ctx_wa      = {alloc_c, srch_slot};
    res_status  = STATUS_OK;
    res_chunk   = '0;
    res_slot    = '0;
    res_ctx     = '0;

    if (act_q == ACT_ALLOC) begin
      if (pool_empty) begin
        res_status = STATUS_POOL_FULL;
      end else begin
        chunk_we = 1'b1;
        if (use_new) begin
          opened_next = opened + LINK_W'(1);
        end
        if (!srch_found) begin
          head_next            = cur.link;
          chunk_wd.link        = NULL_LINK;
          chunk_wd.on_list     = 1'b0;
          chunk_wd.lowest_free = s_eff;
          res_status           = STATUS_POOL_FULL;
        end else begin
          chunk_wd.slot_map    = cur.slot_map | srch_bit;
          chunk_wd.lowest_free = srch_next;
          if (srch_next >= s_eff) begin
            head_next        = cur.link;
            chunk_wd.link    = NULL_LINK;
            chunk_wd.on_list = 1'b0;
          end else begin
            head_next = LINK_W'(alloc_c);
          end
          ctx_we    = 1'b1;
          res_chunk = CHUNK_IDX_W'(alloc_c);
          res_slot  = SLOT_IDX_W'(srch_slot);
        end
      end
    end else begin
      chunk_wa = CI_W'(chunk_q);
      if (not_opened) begin
        res_status = STATUS_NOT_OPENED;
      end else if (!slot_hit) begin
        res_status = STATUS_NOT_ALLOCATED;
      end else begin
        chunk_we = 1'b1;
        chunk_wd.slot_map[SLOT_W'(slot_q)] = 1'b0;
        if (!cur.on_list) begin
          chunk_wd.link    = head;
          chunk_wd.on_list = 1'b1;
          head_next        = LINK_W'(chunk_q);
        end
        if (CFG_W'(cur.lowest_free) > CFG_W'(slot_q)) begin
          chunk_wd.lowest_free = LF_W'(slot_q);
        end
        res_ctx = CTX_PORT_W'(ctx_rd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chunk_rd <= chunk_mem[rd_addr];
      ctx_rd   <= ctx_mem[{CI_W'(chunk_index), SLOT_W'(slot_index)}];
      act_q    <= action;
      ctx_in_q <= context_in;
      chunk_q  <= chunk_index;
      slot_q   <= slot_index;
    end
    if (calc_go && chunk_we) begin
      chunk_mem[chunk_wa] <= chunk_wd;
    end
    if (calc_go && ctx_we) begin
      ctx_mem[ctx_wa] <= ctx_in_q[CONTEXT_WIDTH-1:0];
    end
    if (calc_go) begin
      status      <= res_status;
      given_chunk <= res_chunk;
      given_slot  <= res_slot;
      context_out <= res_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slots_cfg <= SLOTS_RESET;
      head      <= NULL_LINK;
      opened    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots_cfg <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (calc_go) begin
            state  <= ST_IDLE;
            head   <= head_next;
            opened <= opened_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (calc_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_opened_bound: assert property (@(posedge clk) disable iff (rst)
    opened <= NULL_LINK)
    else $error("opened chunk count beyond pool size");

  a_head_opened: assert property (@(posedge clk) disable iff (rst)
    (head == NULL_LINK) || (head < opened))
    else $error("list head names an unopened chunk");

  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CALC))
    else $error("accepted transaction not followed by search cycle");

  a_calc_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && out_valid && !out_ready |=> (state == ST_CALC))
    else $error("search cycle left while output register full");

  a_out_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_CALC))
    else $error("result raised without a search cycle");
`endif

endmodule

[rtl/cba_slot_search.sv]
// Free-slot search over one chunk bitmap: lowest and second lowest clear bit
// at or above a start index and below a limit. Depends on cba_pkg.
module cba_slot_search import cba_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  localparam int SLOT_W = $clog2(MAX_SLOTS),
  localparam int LF_W   = $clog2(MAX_SLOTS + 1)
) (
  input  logic [MAX_SLOTS-1:0] slot_map,
  input  logic [LF_W-1:0]      start,
  input  logic [LF_W-1:0]      limit,
  output logic                 found,
  output logic [SLOT_W-1:0]    slot,
  output logic [MAX_SLOTS-1:0] slot_bit,
  output logic [LF_W-1:0]      next_open
);

  logic [MAX_SLOTS-1:0] cand;
  logic [MAX_SLOTS-1:0] rest;
  logic [MAX_SLOTS-1:0] rest_bit;
  logic [SLOT_W-1:0]    rest_slot;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cand[i] = !slot_map[i] && (LF_W'(i) < limit) && (LF_W'(i) >= start);
    end
    slot_bit = cand & (~cand + MAX_SLOTS'(1));
    rest     = cand & ~slot_bit;
    rest_bit = rest & (~rest + MAX_SLOTS'(1));
    found    = |cand;
    slot      = '0;
    rest_slot = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (slot_bit[i]) begin
        slot = slot | SLOT_W'(i);
      end
      if (rest_bit[i]) begin
        rest_slot = rest_slot | SLOT_W'(i);
      end
    end
    next_open = (|rest) ? LF_W'(rest_slot) : limit;
  end

endmodule

[verif/chunked_bitmap_slot_allocator_tb.sv]
// Self-checking testbench for the chunked bitmap slot allocator: a directed table and then
// random allocate/free traffic, each reply checked against its table row if typed, or the
// allocator model kept here. Depends on cba_pkg and the chunked_bitmap_slot_allocator RTL.
module chunked_bitmap_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cba_pkg::*;

  localparam int NUM_CHUNKS     = NUM_CHUNKS_DEF;
  localparam int MAX_SLOTS      = MAX_SLOTS_DEF;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_ITEMS    = 160;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_ROW_COUNT  = 16;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    status_t                st;
    logic [CHUNK_IDX_W-1:0] gc;
    logic [SLOT_IDX_W-1:0]  gs;
    logic [CTX_PORT_W-1:0]  co;
  } reply_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   act;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic [SLOT_IDX_W-1:0]  slot;
    logic [CTX_PORT_W-1:0]  ctx;
    logic [7:0]             reps;
    logic                   typed;
    status_t                st;
    logic [CHUNK_IDX_W-1:0] gc;
    logic [SLOT_IDX_W-1:0]  gs;
    logic [CTX_PORT_W-1:0]  co;
  } dir_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   action = ACT_ALLOC;
  logic [CTX_PORT_W-1:0]  context_in = '0;
  logic [CHUNK_IDX_W-1:0] chunk_index = '0;
  logic [SLOT_IDX_W-1:0]  slot_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [CHUNK_IDX_W-1:0] given_chunk;
  logic [SLOT_IDX_W-1:0]  given_slot;
  logic [CTX_PORT_W-1:0]  context_out;

  // allocator model state
  logic [MAX_SLOTS-1:0]  chunk_map      [NUM_CHUNKS];
  int                    chunk_low_free [NUM_CHUNKS];
  int                    chunk_link     [NUM_CHUNKS];
  bit                    chunk_listed   [NUM_CHUNKS];
  int                    free_head;
  int                    opened_count;
  logic [CTX_PORT_W-1:0] slot_ctx [NUM_CHUNKS*MAX_SLOTS];
  logic [CFG_W-1:0]      slots_cfg;

  reply_t awaited_replies [$];
  int     errors;
  int     sent;
  int     settings_used;
  int     status_seen [4];
  int     tx_idle_pct;
  int     rx_idle_pct;
  int     stall_cycles;

  dir_row_t directed_rows [DIR_ROW_COUNT] = '{
    '{ROW_CFG, ACT_ALLOC, 4'd0, 6'd0, 64'd0, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd0, 6'd0, 64'd0, 8'd1, 1'b1, STATUS_NOT_OPENED, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, ALL_ONES, 8'd1, 1'b1, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd0, 6'd63, 64'd0, 8'd1, 1'b1, STATUS_NOT_ALLOCATED,
      4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd0, 6'd0, 64'd0, 8'd1, 1'b1, STATUS_OK, 4'd0, 6'd0, ALL_ONES},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, 64'd0, 8'd16, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, 64'd7, 8'd1, 1'b1, STATUS_POOL_FULL, 4'd0, 6'd0, 64'd0},
    '{ROW_CFG, ACT_ALLOC, 4'd0, 6'd0, 64'd127, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, 64'd9, 8'd1, 1'b1, STATUS_POOL_FULL, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd5, 6'd0, 64'd0, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, 64'hA5A5_5A5A_F00F_0FF0, 8'd2, 1'b0, STATUS_OK,
      4'd0, 6'd0, 64'd0},
    '{ROW_CFG, ACT_ALLOC, 4'd0, 6'd0, 64'd1, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_ALLOC, 4'd0, 6'd0, 64'd3, 8'd1, 1'b1, STATUS_POOL_FULL, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd5, 6'd1, 64'd0, 8'd1, 1'b1, STATUS_NOT_ALLOCATED,
      4'd0, 6'd0, 64'd0},
    '{ROW_CFG, ACT_ALLOC, 4'd0, 6'd0, 64'd64, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0},
    '{ROW_REQ, ACT_FREE, 4'd5, 6'd1, 64'd0, 8'd1, 1'b0, STATUS_OK, 4'd0, 6'd0, 64'd0}
  };

  chunked_bitmap_slot_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .context_in  (context_in),
    .chunk_index (chunk_index),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .given_chunk (given_chunk),
    .given_slot  (given_slot),
    .context_out (context_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int slot_limit();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
    return int'(slots_cfg);
  endfunction

  function automatic int lowest_clear(logic [MAX_SLOTS-1:0] map, int n, int start);
    for (int i = start; i < n; i++)
      if (!map[i]) return i;
    return n;
  endfunction

  function automatic reply_t allocator_reply(logic act, logic [CTX_PORT_W-1:0] ctx,
                                             logic [CHUNK_IDX_W-1:0] ch,
                                             logic [SLOT_IDX_W-1:0] sl);
    reply_t r;
    int     s;
    int     c;
    int     k;
    r = '0;
    s = slot_limit();
    if (act == ACT_ALLOC) begin
      if (free_head == NUM_CHUNKS && opened_count < NUM_CHUNKS) begin
        c = opened_count;
        opened_count++;
        chunk_map[c] = '0;
        chunk_low_free[c] = 0;
        chunk_link[c] = NUM_CHUNKS;
        chunk_listed[c] = 1'b1;
        free_head = c;
      end
      if (free_head == NUM_CHUNKS) begin
        r.st = STATUS_POOL_FULL;
      end else begin
        c = free_head;
        k = lowest_clear(chunk_map[c], s, chunk_low_free[c]);
        if (k >= s) begin
          free_head = chunk_link[c];
          chunk_link[c] = NUM_CHUNKS;
          chunk_listed[c] = 1'b0;
          chunk_low_free[c] = s;
          r.st = STATUS_POOL_FULL;
        end else begin
          chunk_map[c][k] = 1'b1;
          chunk_low_free[c] = lowest_clear(chunk_map[c], s, k + 1);
          if (chunk_low_free[c] >= s) begin
            free_head = chunk_link[c];
            chunk_link[c] = NUM_CHUNKS;
            chunk_listed[c] = 1'b0;
          end
          slot_ctx[c*MAX_SLOTS + k] = ctx;
          r.gc = CHUNK_IDX_W'(c);
          r.gs = SLOT_IDX_W'(k);
        end
      end
    end else begin
      c = int'(ch);
      k = int'(sl);
      if (c >= opened_count) begin
        r.st = STATUS_NOT_OPENED;
      end else if (k >= s || !chunk_map[c][k]) begin
        r.st = STATUS_NOT_ALLOCATED;
      end else begin
        chunk_map[c][k] = 1'b0;
        if (!chunk_listed[c]) begin
          chunk_link[c] = free_head;
          free_head = c;
          chunk_listed[c] = 1'b1;
        end
        if (chunk_low_free[c] > k) chunk_low_free[c] = k;
        r.co = slot_ctx[c*MAX_SLOTS + k];
        slot_ctx[c*MAX_SLOTS + k] = '0;
      end
    end
    return r;
  endfunction

  // pick a slot that is in use and below the current slot count
  function automatic bit pick_live_slot(output logic [CHUNK_IDX_W-1:0] ch,
                                        output logic [SLOT_IDX_W-1:0] sl);
    int s;
    int c0;
    int b0;
    int c;
    int b;
    s = slot_limit();
    c0 = $urandom_range(NUM_CHUNKS - 1);
    b0 = $urandom_range(MAX_SLOTS - 1);
    ch = '0;
    sl = '0;
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      c = (c0 + i) % NUM_CHUNKS;
      if (c < opened_count) begin
        for (int j = 0; j < MAX_SLOTS; j++) begin
          b = (b0 + j) % MAX_SLOTS;
          if (b < s && chunk_map[c][b]) begin
            ch = CHUNK_IDX_W'(c);
            sl = SLOT_IDX_W'(b);
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic act, input logic [CTX_PORT_W-1:0] ctx,
                              input logic [CHUNK_IDX_W-1:0] ch,
                              input logic [SLOT_IDX_W-1:0] sl,
                              input bit typed, input reply_t typed_reply);
    reply_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    context_in  <= ctx;
    chunk_index <= ch;
    slot_index  <= sl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = allocator_reply(act, ctx, ch, sl);
    awaited_replies.push_back(typed ? typed_reply : r);
    sent++;
    @(negedge clk);
  endtask

  // drain all replies, let the block settle, then write the slot count
  task automatic write_slots(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slots_cfg = value;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      status_seen[status]++;
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected reply, expected none, actual status %0d chunk %0d slot %0d",
                 $time, status, given_chunk, given_slot);
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 64'(want.st), 64'(status));
        check_field("given_chunk", 64'(want.gc), 64'(given_chunk));
        check_field("given_slot", 64'(want.gs), 64'(given_slot));
        check_field("context_out", want.co, context_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transaction for %0d cycles, %0d replies outstanding",
               $time, stall_cycles, awaited_replies.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t               row;
    logic [CFG_W-1:0]       phase_slots [PHASE_COUNT];
    int                     alloc_pct;
    int                     roll;
    logic                   act;
    logic [CTX_PORT_W-1:0]  ctx;
    logic [CHUNK_IDX_W-1:0] ch;
    logic [SLOT_IDX_W-1:0]  sl;

    errors = 0;
    sent = 0;
    settings_used = 0;
    stall_cycles = 0;
    status_seen = '{0, 0, 0, 0};
    tx_idle_pct = 31;
    rx_idle_pct = 55;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      chunk_map[c] = '0;
      chunk_low_free[c] = 0;
      chunk_link[c] = NUM_CHUNKS;
      chunk_listed[c] = 1'b0;
    end
    free_head = NUM_CHUNKS;
    opened_count = 0;
    slots_cfg = SLOTS_RESET;
    phase_slots = '{7'd64, 7'd5, 7'd127, 7'd2, 7'd0, 7'd33, 7'd64, 7'd9, 7'd0};
    phase_slots[PHASE_COUNT-1] = CFG_W'($urandom_range(1, 127));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_slots(row.ctx[CFG_W-1:0]);
      end else begin
        for (int r = 0; r < row.reps; r++)
          send_request(row.act, row.ctx ^ 64'(r), row.chunk, row.slot, row.typed,
                       '{row.st, row.gc, row.gs, row.co});
      end
    end

    alloc_pct = 30;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_slots(phase_slots[ph]);
      tx_idle_pct = (ph < 3) ? 31 : (ph < 6) ? 55 : 0;
      rx_idle_pct = (ph < 3) ? 55 : (ph < 6) ? 31 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate filling and draining bursts so the pool runs full and empty
        if (n % 40 == 0) alloc_pct = (alloc_pct == 75) ? 30 : 75;
        roll = $urandom_range(99);
        act = ACT_ALLOC;
        ctx = {$urandom, $urandom};
        ch = CHUNK_IDX_W'($urandom_range(NUM_CHUNKS - 1));
        sl = SLOT_IDX_W'($urandom_range(MAX_SLOTS - 1));
        if (roll >= 85) begin
          act = ACT_FREE;
        end else if ($urandom_range(99) >= alloc_pct) begin
          act = ACT_FREE;
          void'(pick_live_slot(ch, sl));
        end
        send_request(act, ctx, ch, sl, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d requests over %0d slot-count settings and three idle patterns",
             sent, settings_used);
    $display("Replies seen: %0d ok, %0d pool full, %0d unopened chunk, %0d unallocated slot",
             status_seen[STATUS_OK], status_seen[STATUS_POOL_FULL],
             status_seen[STATUS_NOT_OPENED], status_seen[STATUS_NOT_ALLOCATED]);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
